### rtl/core/edf_pkg.sv
// Shared types and constants of the earliest-deadline-first scheduler.
package edf_pkg;

	localparam logic [3:0] K_CREATE    = 4'd0;
	localparam logic [3:0] K_REMOVE    = 4'd1;
	localparam logic [3:0] K_COMPLETE  = 4'd2;
	localparam logic [3:0] K_TICK      = 4'd3;
	localparam logic [3:0] K_SELECT    = 4'd4;
	localparam logic [3:0] K_ADMIT     = 4'd5;
	localparam logic [3:0] K_EXACT     = 4'd6;
	localparam logic [3:0] K_QUERY     = 4'd7;
	localparam logic [3:0] K_RESET_ONE = 4'd8;
	localparam logic [3:0] K_RESET_ALL = 4'd9;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	localparam logic [1:0] EV_REPLY   = 2'd0;
	localparam logic [1:0] EV_RELEASE = 2'd1;
	localparam logic [1:0] EV_MISS    = 2'd2;

	localparam logic [1:0] PH_READY   = 2'd0;
	localparam logic [1:0] PH_RUNNING = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	localparam logic [31:0] UTIL_ONE = 32'd1000;
	localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        start;
		logic [23:0] budget;
		logic [23:0] period;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic [1:0]         ev;
		logic [1:0]         st;
		logic [7:0]         id;
		logic [2:0]         slot;
		logic               adm;
		logic [15:0]        jobs;
		logic [15:0]        miss;
		logic signed [31:0] slack;
		logic [31:0]        used;
		logic               last;
	} res_t;

endpackage

### rtl/core/edf_deadline_scheduler.sv
// Steps: find walks the slots one a cycle; create then runs the utilization division and the total
// sum over every slot; tick walks the order list twice (releases, then misses); select walks it
// once; a stalled output holds the request in its current state.
// One request is worked at a time; the next is taken once its reply is in the output register.
// Reset empties the task table and clears time, utilization and the order list at once.
module edf_deadline_scheduler #(
	parameter int MAX_TASKS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// task_id[7:0], period[31:8], rel_deadline[55:32], exec_budget[79:56], ready_mask[87:80]
	input  logic [87:0]  s_tdata,
	// kind[3:0]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], out_task_id[9:2], slot[12:10], admitted[13], jobs_done[29:14],
	// misses[45:30], slack[77:46], used_time[109:78], utilization[141:110], zero fill
	output logic [143:0] m_tdata,
	// event_res[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_FIND = 18'h00002,
		S_CWR  = 18'h00004,
		S_DIV  = 18'h00008,
		S_APP  = 18'h00010,
		S_SUM  = 18'h00020,
		S_RMS  = 18'h00040,
		S_RMSH = 18'h00080,
		S_ADV1 = 18'h00100,
		S_ADV2 = 18'h00200,
		S_T1L  = 18'h00400,
		S_T1X  = 18'h00800,
		S_T2L  = 18'h01000,
		S_T2X  = 18'h02000,
		S_SL   = 18'h04000,
		S_SX   = 18'h08000,
		S_RALL = 18'h10000,
		S_EMIT = 18'h20000
	} state_t;

	state_t state_q;

	logic [MAX_TASKS-1:0] used_q;
	logic [7:0]  task_q   [MAX_TASKS];
	logic [23:0] period_q [MAX_TASKS];
	logic [23:0] reldl_q  [MAX_TASKS];
	logic [23:0] budget_q [MAX_TASKS];
	logic [31:0] nrel_q   [MAX_TASKS];
	logic [31:0] absdl_q  [MAX_TASKS];
	logic [31:0] run_q    [MAX_TASKS];
	logic [15:0] jobs_q   [MAX_TASKS];
	logic [15:0] miss_q   [MAX_TASKS];
	logic [1:0]  phase_q  [MAX_TASKS];
	logic [31:0] util_q   [MAX_TASKS];
	logic [SW-1:0] order_q [MAX_TASKS];
	logic [CW-1:0] count_q;
	logic [31:0]   util_total_q;
	logic [31:0]   now_q;

	logic [3:0]  kind_q;
	logic [7:0]  id_q;
	logic [23:0] per_q;
	logic [23:0] dl_q;
	logic [23:0] bud_q;
	logic [7:0]  rmask_q;

	logic [SW-1:0] cur_q;
	logic [SW-1:0] sel_q;
	logic [SW-1:0] free_q;
	logic          free_v_q;
	logic          fresh_q;
	logic [CW-1:0] oi_q;
	logic          adv_tick_q;
	logic [31:0]   acc_q;
	logic          best_v_q;
	logic [SW-1:0] best_q;
	logic [31:0]   best_dl_q;
	logic [7:0]    best_task_q;
	logic          div_start_q;

	logic [1:0] res_st_q;
	logic [7:0] res_id_q;
	logic [2:0] res_slot_q;
	logic       res_adm_q;
	logic       qhit_q;

	logic         m_tvalid_q;
	edf_pkg::res_t out_q;
	logic [31:0]  out_util_q;

	edf_pkg::div_req_t div_req;
	edf_pkg::div_rsp_t div_rsp;

	edf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req.start  = div_start_q;
	assign div_req.budget = bud_q;
	assign div_req.period = per_q;

	logic        accept;
	logic [3:0]  in_kind;
	logic [7:0]  in_id;
	logic [23:0] in_per;
	logic [23:0] in_dl;
	logic [23:0] in_bud;
	logic [23:0] in_dl_eff;
	logic        out_free;
	logic        cur_used;
	logic        hit;
	logic        last_slot;
	logic [1:0]  cur_phase;
	logic [31:0] nrel_diff;
	logic [31:0] abs_diff;
	logic        rel_c;
	logic        miss_c;
	logic        elig;
	logic [31:0] cur_wide;
	logic [32:0] sum33;
	logic [31:0] acc_next;
	logic [32:0] tsum;
	logic [CW-1:0] oim1;
	logic [SW-1:0] oslot;
	logic        emit_en;
	edf_pkg::res_t em;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_kind   = s_tuser;
	assign in_id     = s_tdata[7:0];
	assign in_per    = s_tdata[31:8];
	assign in_dl     = s_tdata[55:32];
	assign in_bud    = s_tdata[79:56];
	assign in_dl_eff = (in_dl == 24'd0) ? in_per : in_dl;

	assign out_free  = !m_tvalid_q || m_tready;
	assign cur_used  = used_q[cur_q];
	assign hit       = cur_used && (task_q[cur_q] == id_q);
	assign last_slot = (cur_q == SW'(MAX_TASKS - 1));
	assign cur_phase = phase_q[cur_q];
	assign nrel_diff = now_q - nrel_q[cur_q];
	assign abs_diff  = now_q - absdl_q[cur_q];
	assign rel_c     = cur_used && (cur_phase == edf_pkg::PH_DONE) && !nrel_diff[31];
	assign miss_c    = cur_used && !abs_diff[31] &&
	                   ((cur_phase == edf_pkg::PH_READY) || (cur_phase == edf_pkg::PH_RUNNING));
	assign cur_wide  = 32'(cur_q);
	assign elig      = cur_used && (cur_wide < 32'd8) && rmask_q[cur_wide[2:0]] &&
	                   ((cur_phase == edf_pkg::PH_READY) || (cur_phase == edf_pkg::PH_RUNNING));
	assign sum33     = {1'b0, acc_q} + {1'b0, util_q[cur_q]};
	assign acc_next  = cur_used ? (sum33[32] ? edf_pkg::SAT32 : sum33[31:0]) : acc_q;
	assign tsum      = {1'b0, util_total_q} + {1'b0, div_rsp.quot};
	assign oim1      = oi_q - 1'b1;
	assign oslot     = order_q[oi_q[SW-1:0]];

	always_comb begin
		emit_en = 1'b0;
		em      = '0;
		case (state_q)
			S_T1X: begin
				if (rel_c && out_free) begin
					emit_en = 1'b1;
					em.ev   = edf_pkg::EV_RELEASE;
					em.id   = task_q[cur_q];
					em.slot = 3'(cur_q);
				end
			end
			S_T2X: begin
				if (miss_c && out_free) begin
					emit_en = 1'b1;
					em.ev   = edf_pkg::EV_MISS;
					em.id   = task_q[cur_q];
					em.slot = 3'(cur_q);
				end
			end
			S_EMIT: begin
				emit_en = out_free;
				em.ev   = edf_pkg::EV_REPLY;
				em.st   = res_st_q;
				em.id   = res_id_q;
				em.slot = res_slot_q;
				em.adm  = res_adm_q;
				em.last = 1'b1;
				if (qhit_q) begin
					em.jobs  = jobs_q[cur_q];
					em.miss  = miss_q[cur_q];
					em.slack = $signed(absdl_q[cur_q] - now_q);
					em.used  = run_q[cur_q];
				end
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_en) begin
			m_tvalid_q <= 1'b1;
			out_q      <= em;
			out_util_q <= util_total_q;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.ev;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {2'b00, out_util_q, out_q.used, out_q.slack, out_q.miss, out_q.jobs,
	                   out_q.adm, out_q.slot, out_q.id, out_q.st};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			count_q      <= '0;
			util_total_q <= '0;
			now_q        <= '0;
			div_start_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q     <= in_kind;
						id_q       <= in_id;
						per_q      <= in_per;
						bud_q      <= in_bud;
						rmask_q    <= s_tdata[87:80];
						dl_q       <= (in_kind == edf_pkg::K_CREATE) ? in_dl_eff : in_dl;
						res_st_q   <= edf_pkg::ST_OK;
						res_id_q   <= in_id;
						res_slot_q <= '0;
						res_adm_q  <= 1'b0;
						qhit_q     <= 1'b0;
						cur_q      <= '0;
						free_v_q   <= 1'b0;
						oi_q       <= '0;
						best_v_q   <= 1'b0;
						adv_tick_q <= 1'b0;
						case (in_kind)
							edf_pkg::K_CREATE: begin
								if (in_per == 24'd0 || in_bud > in_dl_eff) begin
									res_st_q <= edf_pkg::ST_BAD;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_FIND;
								end
							end
							edf_pkg::K_REMOVE, edf_pkg::K_COMPLETE, edf_pkg::K_QUERY,
							edf_pkg::K_RESET_ONE: begin
								state_q <= S_FIND;
							end
							edf_pkg::K_TICK: begin
								now_q    <= now_q + 32'd1;
								res_id_q <= '0;
								state_q  <= S_T1L;
							end
							edf_pkg::K_SELECT: begin
								res_id_q <= '0;
								state_q  <= S_SL;
							end
							edf_pkg::K_ADMIT, edf_pkg::K_EXACT: begin
								if (in_per == 24'd0) begin
									res_st_q <= edf_pkg::ST_BAD;
									state_q  <= S_EMIT;
								end else begin
									div_start_q <= 1'b1;
									state_q     <= S_DIV;
								end
							end
							edf_pkg::K_RESET_ALL: begin
								res_id_q <= '0;
								state_q  <= S_RALL;
							end
							default: begin
								res_st_q <= edf_pkg::ST_BAD;
								state_q  <= S_EMIT;
							end
						endcase
					end
				end
				S_FIND: begin
					if (hit) begin
						sel_q      <= cur_q;
						res_slot_q <= 3'(cur_q);
						case (kind_q)
							edf_pkg::K_CREATE: begin
								fresh_q <= 1'b0;
								state_q <= S_CWR;
							end
							edf_pkg::K_REMOVE: begin
								used_q[cur_q] <= 1'b0;
								state_q       <= S_RMS;
							end
							edf_pkg::K_COMPLETE: begin
								if (cur_phase == edf_pkg::PH_RUNNING) begin
									jobs_q[cur_q]  <= jobs_q[cur_q] + 16'd1;
									phase_q[cur_q] <= edf_pkg::PH_DONE;
									run_q[cur_q]   <= '0;
									state_q        <= S_ADV1;
								end else begin
									state_q <= S_EMIT;
								end
							end
							edf_pkg::K_QUERY: begin
								qhit_q  <= 1'b1;
								state_q <= S_EMIT;
							end
							default: begin
								jobs_q[cur_q] <= '0;
								miss_q[cur_q] <= '0;
								state_q       <= S_EMIT;
							end
						endcase
					end else if (last_slot) begin
						if (kind_q == edf_pkg::K_CREATE) begin
							if (free_v_q || !cur_used) begin
								if (free_v_q) begin
									cur_q <= free_q;
								end
								fresh_q <= 1'b1;
								state_q <= S_CWR;
							end else begin
								res_st_q <= edf_pkg::ST_FULL;
								state_q  <= S_EMIT;
							end
						end else begin
							res_st_q <= edf_pkg::ST_NONE;
							state_q  <= S_EMIT;
						end
					end else begin
						if (!cur_used && !free_v_q) begin
							free_v_q <= 1'b1;
							free_q   <= cur_q;
						end
						cur_q <= cur_q + 1'b1;
					end
				end
				S_CWR: begin
					used_q[cur_q]   <= 1'b1;
					task_q[cur_q]   <= id_q;
					period_q[cur_q] <= per_q;
					reldl_q[cur_q]  <= dl_q;
					budget_q[cur_q] <= bud_q;
					absdl_q[cur_q]  <= now_q + 32'(dl_q);
					nrel_q[cur_q]   <= now_q;
					run_q[cur_q]    <= '0;
					jobs_q[cur_q]   <= '0;
					miss_q[cur_q]   <= '0;
					phase_q[cur_q]  <= edf_pkg::PH_READY;
					res_slot_q      <= 3'(cur_q);
					div_start_q     <= 1'b1;
					state_q         <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (kind_q == edf_pkg::K_CREATE) begin
							util_q[cur_q] <= div_rsp.quot;
							state_q       <= S_APP;
						end else begin
							res_adm_q <= (tsum <= 33'(edf_pkg::UTIL_ONE)) &&
							             !(kind_q == edf_pkg::K_EXACT && dl_q > per_q);
							state_q   <= S_EMIT;
						end
					end
				end
				S_APP: begin
					if (fresh_q && count_q < CW'(MAX_TASKS)) begin
						order_q[count_q[SW-1:0]] <= cur_q;
						count_q                  <= count_q + 1'b1;
					end
					cur_q   <= '0;
					acc_q   <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q <= acc_next;
					if (last_slot) begin
						util_total_q <= acc_next;
						state_q      <= S_EMIT;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_RMS: begin
					if (oi_q >= count_q) begin
						cur_q   <= '0;
						acc_q   <= '0;
						state_q <= S_SUM;
					end else begin
						if (oslot == sel_q) begin
							state_q <= S_RMSH;
						end
						oi_q <= oi_q + 1'b1;
					end
				end
				S_RMSH: begin
					if (oi_q < count_q) begin
						order_q[oim1[SW-1:0]] <= oslot;
						oi_q                  <= oi_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						cur_q   <= '0;
						acc_q   <= '0;
						state_q <= S_SUM;
					end
				end
				S_ADV1: begin
					nrel_q[cur_q] <= nrel_q[cur_q] + 32'(period_q[cur_q]);
					state_q       <= S_ADV2;
				end
				S_ADV2: begin
					absdl_q[cur_q] <= nrel_q[cur_q] + 32'(reldl_q[cur_q]);
					if (adv_tick_q) begin
						oi_q    <= oi_q + 1'b1;
						state_q <= S_T2L;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_T1L: begin
					if (oi_q < count_q) begin
						cur_q   <= oslot;
						state_q <= S_T1X;
					end else begin
						oi_q    <= '0;
						state_q <= S_T2L;
					end
				end
				S_T1X: begin
					if (rel_c) begin
						if (out_free) begin
							phase_q[cur_q] <= edf_pkg::PH_READY;
							run_q[cur_q]   <= '0;
							oi_q           <= oi_q + 1'b1;
							state_q        <= S_T1L;
						end
					end else begin
						if (cur_used && cur_phase == edf_pkg::PH_RUNNING) begin
							run_q[cur_q] <= run_q[cur_q] + 32'd1;
						end
						oi_q    <= oi_q + 1'b1;
						state_q <= S_T1L;
					end
				end
				S_T2L: begin
					if (oi_q < count_q) begin
						cur_q   <= oslot;
						state_q <= S_T2X;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_T2X: begin
					if (miss_c) begin
						if (out_free) begin
							miss_q[cur_q]  <= miss_q[cur_q] + 16'd1;
							phase_q[cur_q] <= edf_pkg::PH_DONE;
							adv_tick_q     <= 1'b1;
							state_q        <= S_ADV1;
						end
					end else begin
						oi_q    <= oi_q + 1'b1;
						state_q <= S_T2L;
					end
				end
				S_SL: begin
					if (oi_q < count_q) begin
						cur_q   <= oslot;
						state_q <= S_SX;
					end else if (!best_v_q) begin
						res_st_q <= edf_pkg::ST_NONE;
						state_q  <= S_EMIT;
					end else begin
						phase_q[best_q] <= edf_pkg::PH_RUNNING;
						res_id_q        <= best_task_q;
						res_slot_q      <= 3'(best_q);
						state_q         <= S_EMIT;
					end
				end
				S_SX: begin
					if (elig && (!best_v_q || absdl_q[cur_q] < best_dl_q)) begin
						best_v_q    <= 1'b1;
						best_q      <= cur_q;
						best_dl_q   <= absdl_q[cur_q];
						best_task_q <= task_q[cur_q];
					end
					oi_q    <= oi_q + 1'b1;
					state_q <= S_SL;
				end
				S_RALL: begin
					if (cur_used) begin
						jobs_q[cur_q] <= '0;
						miss_q[cur_q] <= '0;
					end
					if (last_slot) begin
						state_q <= S_EMIT;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/edf_div.sv
// Bit-serial utilization divider: budget*1000/period, saturated to 32 bits.
module edf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  edf_pkg::div_req_t req,
	output edf_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [33:0] num_q;
	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [24:0] trial;
	logic        take;

	assign trial = {rem_q, num_q[33]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd34;
				num_q  <= 34'(req.budget) * 34'(edf_pkg::UTIL_ONE);
				rem_q  <= '0;
				den_q  <= req.period;
			end else if (busy_q) begin
				rem_q <= take ? 24'(trial - {1'b0, den_q}) : trial[23:0];
				num_q <= {num_q[32:0], take};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = (|num_q[33:32]) ? edf_pkg::SAT32 : num_q[31:0];

endmodule
